// ===== rtl/stepper_position_follower_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stepper position follower
// Concurrent property wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef STEPPER_POSITION_FOLLOWER_UNIT_MACROS_SVH
`define STEPPER_POSITION_FOLLOWER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spf assertion failed: same-cycle implication");
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spf assertion failed: next-cycle implication");
`else
`define SPF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the stepper position follower.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_POS_PER_STEP  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALL_ON       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALL_OFF      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_GAP     = 2'd3;

   // reset values of the registers
   localparam logic [15:0] POS_PER_STEP_RST = 16'd59;
   localparam logic [11:0] HALL_ON_RST      = 12'd2190;
   localparam logic [11:0] HALL_OFF_RST     = 12'd2000;
   localparam logic [15:0] INDEX_GAP_RST    = 16'd3000;

   // half period arithmetic
   localparam int SLOW_BASE  = 1000;
   localparam int SLOW_SCALE = 5000;
   localparam int FAST_SCALE = 5500;
   localparam int FAST_FLOOR = 50;
   localparam int MAG_LIMIT  = 32767;

   // direction codes (two bit signed)
   localparam logic [1:0] DIR_STOP = 2'b00;
   localparam logic [1:0] DIR_FWD  = 2'b01;
   localparam logic [1:0] DIR_REV  = 2'b11;

   typedef struct packed {
      logic load;
      logic detect;
      logic mul1;
      logic div1;
      logic fast;
      logic mul2;
      logic div2;
      logic mod_step;
      logic commit;
   } spf_cmd_type;

   typedef struct packed {
      logic mod_last;
   } spf_sts_type;

endpackage

// ===== rtl/spf_ctrl.sv =====
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer of the follower: steps the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`include "stepper_position_follower_unit_macros.svh"

module spf_ctrl
   import spf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output spf_cmd_type cmd,
   input  spf_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DETECT,
      ST_MUL1,
      ST_DIV1,
      ST_FAST,
      ST_MUL2,
      ST_DIV2,
      ST_MOD,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.detect   = (state_ff == ST_DETECT);
      cmd.mul1     = (state_ff == ST_MUL1);
      cmd.div1     = (state_ff == ST_DIV1);
      cmd.fast     = (state_ff == ST_FAST);
      cmd.mul2     = (state_ff == ST_MUL2);
      cmd.div2     = (state_ff == ST_DIV2);
      cmd.mod_step = (state_ff == ST_MOD);
      cmd.commit   = (state_ff == ST_COMMIT) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DETECT;
         end
         ST_DETECT: state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_DIV1;
         ST_DIV1:   state_in = ST_FAST;
         ST_FAST:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_DIV2;
         ST_DIV2:   state_in = ST_MOD;
         ST_MOD: begin
            if (sts.mod_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SPF_ASSERT_IMPLIES(a_commit_slot_free, clock, reset, cmd.commit, !rsp_valid_ff || rsp_tready)
   `SPF_ASSERT_NEXT(a_commit_shows_rsp, clock, reset, cmd.commit, rsp_tvalid)
   `SPF_ASSERT_NEXT(a_accept_blocks_next, clock, reset, req_tvalid && req_tready, !req_tready)
   `SPF_ASSERT_IMPLIES(a_mod_only_busy, clock, reset, cmd.mod_step, !req_tready && !cmd.load)

endmodule

// ===== rtl/spf_datapath.sv =====
// ----------------------------------------------------------------------------
// spf_datapath
// Registers, index detector, half period chain and serial modulo unit.
// ----------------------------------------------------------------------------
module spf_datapath
   import spf_pkg::*;
#(
   parameter  int POSITION_BITS = 16,
   parameter  int HALL_BITS     = 12,
   localparam int REQ_W = ((POSITION_BITS + 16 + HALL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((POSITION_BITS + 17 + 7) / 8) * 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_W-1:0]      req_tdata,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  spf_cmd_type           cmd,
   output spf_sts_type           sts
);

   localparam int CNT_W = (POSITION_BITS > 1) ? $clog2(POSITION_BITS) : 1;

   // exact floor(x / 255) for x below 255 * 2^13, by folding the high part twice
   function automatic logic [12:0] div255(input logic [20:0] x);
      logic [12:0] q0;
      logic [13:0] r0;
      logic [5:0]  q1;
      logic [8:0]  r1;
      logic        c;
      q0 = x[20:8];
      r0 = 14'(q0) + 14'(x[7:0]);
      q1 = r0[13:8];
      r1 = 9'(q1) + 9'(r0[7:0]);
      c  = (r1 >= 9'd255);
      return q0 + 13'(q1) + 13'(c);
   endfunction

   // exact floor(x / 32767) for x below 32767 * 2^13; one correction suffices
   function automatic logic [12:0] div32767(input logic [27:0] x);
      logic [12:0] q0;
      logic [15:0] r0;
      logic        c;
      q0 = x[27:15];
      r0 = 16'(q0) + 16'(x[14:0]);
      c  = (r0 >= 16'(MAG_LIMIT));
      return q0 + 13'(c);
   endfunction

   // configuration
   logic [15:0] pps_ff;
   logic [11:0] hall_on_ff, hall_off_ff;
   logic [15:0] gap_ff;

   // request fields
   logic [POSITION_BITS-1:0] goal_ff;
   logic [7:0]               smin_ff, smax_ff;
   logic [HALL_BITS-1:0]     hall_ff;

   // follower state
   logic [POSITION_BITS-1:0] pos_ff;
   logic [1:0]               last_dir_ff;
   logic                     mark_ff;

   // working registers
   logic [1:0]               dir_ff;
   logic [14:0]              mag_ff;
   logic [20:0]              p_slow_ff, p_raw_ff;
   logic [12:0]              slow_ff, raw_ff, fast_ff, span_ff, half_ff;
   logic [14:0]              magc_ff;
   logic [27:0]              prod_ff;
   logic [POSITION_BITS-1:0] shreg_ff;
   logic [15:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   // detector and difference
   logic [HALL_BITS-1:0]     on_lvl, off_lvl;
   logic                     rise, mark_a, mark_n;
   logic [POSITION_BITS-1:0] gap_half, pos_a, diff, mag_full;
   logic [1:0]               dir_n;
   logic [32:0]              mag_wide;
   logic [14:0]              mag_n;

   // half period chain
   logic [13:0]              raw_plus;
   logic [12:0]              fast_n;

   // modulo step and commit
   logic [16:0]              rem_t;
   logic                     moving, pulse;
   logic [POSITION_BITS-1:0] pos_moved;
   logic [12:0]              half_out;

   always_comb begin
      on_lvl   = HALL_BITS'(hall_on_ff);
      off_lvl  = HALL_BITS'(hall_off_ff);
      gap_half = POSITION_BITS'(gap_ff >> 1);
      rise     = !mark_ff && (hall_ff > on_lvl);
      mark_a   = mark_ff || rise;
      mark_n   = mark_a && !(hall_ff < off_lvl);
      pos_a    = pos_ff;
      if (rise) begin
         if (last_dir_ff == DIR_FWD) begin
            pos_a = -gap_half;
         end else if (last_dir_ff == DIR_REV) begin
            pos_a = gap_half;
         end
      end
      diff = goal_ff - pos_a;
      if (diff == '0) begin
         dir_n    = DIR_STOP;
         mag_full = '0;
      end else if (diff[POSITION_BITS-1]) begin
         dir_n    = DIR_REV;
         mag_full = -diff;
      end else begin
         dir_n    = DIR_FWD;
         mag_full = diff;
      end
      mag_wide = 33'(mag_full);
      mag_n    = (mag_wide > 33'(MAG_LIMIT)) ? 15'(MAG_LIMIT) : 15'(mag_full);
   end

   always_comb begin
      raw_plus = 14'(raw_ff) + 14'(FAST_FLOOR);
      fast_n   = (raw_plus > 14'(slow_ff)) ? 13'(FAST_FLOOR) : (slow_ff - raw_ff);
   end

   always_comb begin
      rem_t = {rem_ff, shreg_ff[POSITION_BITS-1]};
      if (rem_t >= {1'b0, pps_ff}) begin
         rem_in = 16'(rem_t - {1'b0, pps_ff});
      end else begin
         rem_in = 16'(rem_t);
      end
   end

   always_comb begin
      moving    = (dir_ff != DIR_STOP);
      pulse     = moving && (pps_ff != '0) && (rem_ff == '0);
      half_out  = moving ? half_ff : '0;
      pos_moved = pos_ff;
      if (dir_ff == DIR_FWD) begin
         pos_moved = pos_ff + POSITION_BITS'(1);
      end else if (dir_ff == DIR_REV) begin
         pos_moved = pos_ff - POSITION_BITS'(1);
      end
   end

   assign sts.mod_last = (cnt_ff == CNT_W'(POSITION_BITS - 1));
   assign rsp_tdata    = rsp_data_ff;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff      <= POS_PER_STEP_RST;
         hall_on_ff  <= HALL_ON_RST;
         hall_off_ff <= HALL_OFF_RST;
         gap_ff      <= INDEX_GAP_RST;
         pos_ff      <= '0;
         last_dir_ff <= DIR_STOP;
         mark_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_POS_PER_STEP: pps_ff      <= csr_wdata;
               CSR_HALL_ON:      hall_on_ff  <= 12'(csr_wdata);
               CSR_HALL_OFF:     hall_off_ff <= 12'(csr_wdata);
               CSR_INDEX_GAP:    gap_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.detect) begin
            pos_ff  <= pos_a;
            mark_ff <= mark_n;
         end
         if (cmd.commit) begin
            pos_ff      <= pos_moved;
            last_dir_ff <= dir_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         goal_ff <= req_tdata[POSITION_BITS-1:0];
         smin_ff <= req_tdata[POSITION_BITS +: 8];
         smax_ff <= req_tdata[POSITION_BITS+8 +: 8];
         hall_ff <= req_tdata[POSITION_BITS+16 +: HALL_BITS];
      end
      if (cmd.detect) begin
         dir_ff <= dir_n;
         mag_ff <= mag_n;
      end
      if (cmd.mul1) begin
         p_slow_ff <= 21'(8'd255 - smin_ff) * 21'(SLOW_SCALE);
         p_raw_ff  <= 21'(smax_ff) * 21'(FAST_SCALE);
         shreg_ff  <= pos_ff;
         rem_ff    <= '0;
         cnt_ff    <= '0;
      end
      if (cmd.div1) begin
         slow_ff <= 13'(SLOW_BASE) + div255(p_slow_ff);
         raw_ff  <= div255(p_raw_ff);
      end
      if (cmd.fast) begin
         fast_ff <= fast_n;
         span_ff <= slow_ff - fast_n;
         magc_ff <= 15'(MAG_LIMIT) - mag_ff;
      end
      if (cmd.mul2) begin
         prod_ff <= 28'(span_ff) * 28'(magc_ff);
      end
      if (cmd.div2) begin
         half_ff <= fast_ff + div32767(prod_ff);
      end
      if (cmd.mod_step) begin
         rem_ff   <= rem_in;
         shreg_ff <= shreg_ff << 1;
         cnt_ff   <= cnt_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         rsp_data_ff <= RSP_W'({mark_ff, pos_moved, half_out, dir_ff, pulse});
      end
   end

endmodule

// ===== rtl/stepper_position_follower_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_position_follower_unit
// Order: an accepted request passes detect, mul1, div1, fast, mul2, div2, mod
//   and commit; its response shows after commit, later only while rsp_tready is low.
// Requests: one at a time, a new one taken only once commit is done; the
//   bit-serial position modulo unit, one bit a cycle, is the longest step.
// Reset: synchronous, active high; registers return to their defaults, the
//   position, last direction and index mark clear, and no response is pending.
// ----------------------------------------------------------------------------
module stepper_position_follower_unit
   import spf_pkg::*;
#(
   parameter  int POSITION_BITS = 16,
   parameter  int HALL_BITS     = 12,
   localparam int REQ_W = ((POSITION_BITS + 16 + HALL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((POSITION_BITS + 17 + 7) / 8) * 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // goal_position, min_speed_level, max_speed_level, hall_sample, zero pad
   input  logic [REQ_W-1:0]      req_tdata,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // step_pulse, direction, half_period_us, position, index_active, zero pad
   output logic [RSP_W-1:0]      rsp_tdata
);

   // The controller walks each request through the fixed chain:
   //   detect   - hysteresis on the hall sample, re-zero on a rising mark,
   //              wrapped difference to the goal, direction and saturated magnitude
   //   mul1     - scale both speed bytes; load the modulo unit with the position
   //   div1     - constant divide by 255 for the slow and raw half periods
   //   fast     - pick the fastest half period and the span to the slow one
   //   mul2     - span times the remaining distance weight
   //   div2     - constant divide by 32767 and add back the fast period
   //   mod      - restoring remainder of position by pos_per_step, one bit a cycle
   //   commit   - move the position, update the last direction, load the response
   // The response register parts the two sides; commit waits only while a
   // previous response is still held.

   spf_cmd_type cmd;
   spf_sts_type sts;

   spf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   spf_datapath #(
      .POSITION_BITS (POSITION_BITS),
      .HALL_BITS     (HALL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== bench/stepper_position_follower_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_follower_unit_tb
// Self-checking bench for the stepper position follower. A directed table of
// ticks and register writes runs first. Random phases follow, each under its
// own register setting: goals are mostly held long enough to be reached, and
// the hall sample drifts across the thresholds. A bit-accurate predictor of
// position, direction, index mark and half period checks untyped responses.
// ----------------------------------------------------------------------------
module stepper_position_follower_unit_tb;
   import spf_pkg::*;

   localparam int POS_W  = 16;
   localparam int HALL_W = 12;
   localparam int REQ_W  = ((POS_W + 16 + HALL_W + 7) / 8) * 8;
   localparam int RSP_W  = ((POS_W + 17 + 7) / 8) * 8;
   localparam int PHASES = 7;
   localparam int PHASE_TICKS = 182;

   // one response, field by field
   typedef struct packed {
      logic              pulse;
      logic [1:0]        dir;
      logic [12:0]       half;
      logic [POS_W-1:0]  pos;
      logic              mark;
   } tick_result_type;

   typedef enum logic [1:0] {ROW_TICK, ROW_TICK_TYPED, ROW_CSR} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      logic [POS_W-1:0]      goal;
      logic [7:0]            smin;
      logic [7:0]            smax;
      logic [HALL_W-1:0]     hall;
      tick_result_type       want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // goal_position, min_speed_level, max_speed_level, hall_sample, zero pad
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // step_pulse, direction, half_period_us, position, index_active, zero pad
   logic [RSP_W-1:0]      rsp_tdata;

   // sideband that travels with each request: a typed expectation, if any
   logic                  tick_typed;
   tick_result_type       tick_want;

   // mirror of the registers and of the follower state
   logic [15:0]           cfg_steps;
   logic [HALL_W-1:0]     cfg_on;
   logic [HALL_W-1:0]     cfg_off;
   logic [15:0]           cfg_gap;
   logic [POS_W-1:0]      pos_q;
   logic [1:0]            last_dir;
   logic                  mark_q;

   plan_row_type          plan_q[$];
   tick_result_type       follow_q[$];
   tick_result_type       predicted;
   tick_result_type       got;
   tick_result_type       want_r;

   int pace_pct;
   int stall_pct;
   int stall_left;
   int mismatches;
   int sent_count;
   int rsp_count;
   int pulse_count;
   int stop_count;
   int rezero_count;
   int setting_count;

   stepper_position_follower_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Work out one tick: index mark first (rising test before falling test),
   // then the wrapped difference, the half period, the pulse and the move.
   function automatic tick_result_type predict_tick(input logic [POS_W-1:0] goal,
                                                    input logic [7:0] smin,
                                                    input logic [7:0] smax,
                                                    input logic [HALL_W-1:0] hall);
      tick_result_type  r;
      logic [POS_W-1:0] delta;
      int unsigned      mag;
      int unsigned      slow;
      int unsigned      raw;
      int unsigned      fast;
      r = '0;
      if (!mark_q && hall > cfg_on) begin
         mark_q = 1'b1;
         // re-zero to the near edge of the mark; a stopped motor keeps its place
         if (last_dir == DIR_FWD) begin
            pos_q = 16'd0 - (cfg_gap >> 1);
            rezero_count++;
         end else if (last_dir == DIR_REV) begin
            pos_q = cfg_gap >> 1;
            rezero_count++;
         end
      end
      if (mark_q && hall < cfg_off)
         mark_q = 1'b0;

      delta = goal - pos_q;
      mag   = 0;
      if (delta == '0) begin
         r.dir = DIR_STOP;
      end else if (delta[POS_W-1]) begin
         // exactly half the range lands here, i.e. counts as backwards
         r.dir = DIR_REV;
         mag   = 32'h10000 - delta;
      end else begin
         r.dir = DIR_FWD;
         mag   = delta;
      end
      if (mag > MAG_LIMIT)
         mag = MAG_LIMIT;
      last_dir = r.dir;

      if (r.dir != DIR_STOP) begin
         slow   = SLOW_BASE + ((255 - 32'(smin)) * SLOW_SCALE) / 255;
         raw    = (32'(smax) * FAST_SCALE) / 255;
         fast   = (raw + FAST_FLOOR > slow) ? FAST_FLOOR : slow - raw;
         r.half = 13'(fast + ((slow - fast) * (MAG_LIMIT - mag)) / MAG_LIMIT);
         if (cfg_steps != 16'd0 && (pos_q % cfg_steps) == 16'd0)
            r.pulse = 1'b1;
         if (r.dir == DIR_FWD)
            pos_q = pos_q + 16'd1;
         else
            pos_q = pos_q - 16'd1;
      end
      r.pos  = pos_q;
      r.mark = mark_q;
      return r;
   endfunction

   // Track register writes and accepted requests; queue one expectation per
   // request, the typed one where the table gives it.
   always @(posedge clock) begin
      if (reset) begin
         cfg_steps = POS_PER_STEP_RST;
         cfg_on    = HALL_ON_RST;
         cfg_off   = HALL_OFF_RST;
         cfg_gap   = INDEX_GAP_RST;
         pos_q     = '0;
         last_dir  = DIR_STOP;
         mark_q    = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_POS_PER_STEP: cfg_steps = csr_wdata;
               CSR_HALL_ON:      cfg_on    = csr_wdata[HALL_W-1:0];
               CSR_HALL_OFF:     cfg_off   = csr_wdata[HALL_W-1:0];
               CSR_INDEX_GAP:    cfg_gap   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predicted = predict_tick(req_tdata[15:0], req_tdata[23:16],
                                     req_tdata[31:24], req_tdata[43:32]);
            follow_q.push_back(tick_typed ? tick_want : predicted);
         end
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pulse = rsp_tdata[0];
         got.dir   = rsp_tdata[2:1];
         got.half  = rsp_tdata[15:3];
         got.pos   = rsp_tdata[31:16];
         got.mark  = rsp_tdata[32];
         rsp_count++;
         pulse_count += got.pulse;
         if (got.dir == DIR_STOP)
            stop_count++;
         if (follow_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response with no request pending", $time);
               $display("   actual   pulse=%0d dir=%0d half=%0d pos=%0d mark=%0d",
                        got.pulse, got.dir, got.half, got.pos, got.mark);
            end
         end else begin
            want_r = follow_q.pop_front();
            if (got.pulse !== want_r.pulse || got.dir !== want_r.dir ||
                got.half !== want_r.half || got.pos !== want_r.pos ||
                got.mark !== want_r.mark) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response %0d wrong", $time, rsp_count);
                  $display("   expected pulse=%0d dir=%0d half=%0d pos=%0d mark=%0d",
                           want_r.pulse, want_r.dir, want_r.half, want_r.pos, want_r.mark);
                  $display("   actual   pulse=%0d dir=%0d half=%0d pos=%0d mark=%0d",
                           got.pulse, got.dir, got.half, got.pos, got.mark);
               end
            end
         end
      end
   end

   // Back-pressure on the response side: random stalls of random stall_left length.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0)
            rsp_tready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
         stall_left = $urandom_range(19, 1);
         rsp_tready <= 1'b0;
      end
   end

   // Append rows to the directed table.
   task automatic tick_row(input logic [POS_W-1:0] goal, input logic [7:0] smin,
                           input logic [7:0] smax, input logic [HALL_W-1:0] hall);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_TICK;
      r.goal = goal;
      r.smin = smin;
      r.smax = smax;
      r.hall = hall;
      plan_q.push_back(r);
   endtask

   task automatic typed_row(input logic [POS_W-1:0] goal, input logic [7:0] smin,
                            input logic [7:0] smax, input logic [HALL_W-1:0] hall,
                            input logic pulse, input logic [1:0] dir,
                            input logic [12:0] half, input logic [POS_W-1:0] pos,
                            input logic mark);
      plan_row_type r;
      r            = '0;
      r.kind       = ROW_TICK_TYPED;
      r.goal       = goal;
      r.smin       = smin;
      r.smax       = smax;
      r.hall       = hall;
      r.want.pulse = pulse;
      r.want.dir   = dir;
      r.want.half  = half;
      r.want.pos   = pos;
      r.want.mark  = mark;
      plan_q.push_back(r);
   endtask

   task automatic csr_row(input logic [CSR_ADDR_W-1:0] addr,
                          input logic [CSR_DATA_W-1:0] value);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.addr  = addr;
      r.value = value;
      plan_q.push_back(r);
   endtask

   // Offer one request and hold it until taken; then maybe idle for a burst.
   task automatic send_tick(input logic [POS_W-1:0] goal, input logic [7:0] smin,
                            input logic [7:0] smax, input logic [HALL_W-1:0] hall,
                            input logic typed, input tick_result_type want);
      req_tdata  <= {4'b0, hall, smax, smin, goal};
      req_tvalid <= 1'b1;
      tick_typed <= typed;
      tick_want  <= want;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (pace_pct != 0 && $urandom_range(99, 0) < pace_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
   endtask

   // Drop the request valid and wait until every expected response is in, or the guard runs out.
   task automatic drain_follow();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (follow_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Give up long after the slowest correct run would have finished.
   initial begin
      #(10_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [15:0]       ph_steps [PHASES];
      logic [HALL_W-1:0] ph_on    [PHASES];
      logic [HALL_W-1:0] ph_off   [PHASES];
      logic [15:0]       ph_gap   [PHASES];
      int                ph_pace  [PHASES];
      int                ph_stall [PHASES];
      logic [POS_W-1:0]  goal_hold;
      logic [7:0]        smin;
      logic [7:0]        smax;
      int                hall_now;
      int                sel;
      int                lead;
      plan_row_type      row;

      clock      = 1'b0;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b1;
      tick_typed = 1'b0;
      tick_want  = '0;
      pace_pct   = 15;
      stall_pct  = 15;
      stall_left = 0;
      mismatches = 0;
      sent_count = 0;
      rsp_count  = 0;
      pulse_count   = 0;
      stop_count    = 0;
      rezero_count  = 0;
      setting_count = 1;

      // -------- directed table (reset registers until the first write) ------
      // at goal after reset
      typed_row(16'h0000, 8'd0, 8'd0, 12'd0, 1'b0, DIR_STOP, 13'd0, 16'd0, 1'b0);
      // one step forward, min speed byte at 255: half period is just the slow base
      typed_row(16'h0001, 8'd255, 8'd0, 12'd0, 1'b1, DIR_FWD, 13'd1000, 16'd1, 1'b0);
      typed_row(16'h0001, 8'd0, 8'd255, 12'd0, 1'b0, DIR_STOP, 13'd0, 16'd1, 1'b0);
      // difference of exactly half the range: backwards, magnitude saturated
      typed_row(16'h8001, 8'd0, 8'd255, 12'd0, 1'b0, DIR_REV, 13'd500, 16'd0, 1'b0);
      // fastest possible: raw reduction exceeds the slow figure, floor applies
      typed_row(16'h8000, 8'd255, 8'd255, 12'd0, 1'b1, DIR_REV, 13'd50, 16'hFFFF, 1'b0);
      // slowest possible half period
      typed_row(16'h7FFF, 8'd0, 8'd0, 12'd0, 1'b0, DIR_REV, 13'd6000, 16'hFFFE, 1'b0);
      // mark rises after moving backwards: re-zero to plus half the gap
      typed_row(16'd1500, 8'd128, 8'd128, 12'd4095, 1'b0, DIR_STOP, 13'd0, 16'd1500, 1'b1);
      // inside the hysteresis band the mark holds
      typed_row(16'd1500, 8'd1, 8'd254, 12'd2100, 1'b0, DIR_STOP, 13'd0, 16'd1500, 1'b1);
      typed_row(16'd1500, 8'd2, 8'd3, 12'd1999, 1'b0, DIR_STOP, 13'd0, 16'd1500, 1'b0);
      // mark rises while stopped: position left alone
      typed_row(16'd1500, 8'd9, 8'd9, 12'd2191, 1'b0, DIR_STOP, 13'd0, 16'd1500, 1'b1);
      typed_row(16'd1501, 8'd0, 8'd0, 12'd2190, 1'b0, DIR_FWD, 13'd6000, 16'd1501, 1'b1);
      tick_row(16'd1700, 8'hAA, 8'h55, 12'd0);
      // mark rises after moving forwards: re-zero to minus half the gap
      tick_row(16'd1700, 8'h55, 8'hAA, 12'hFFF);
      tick_row(16'h4000, 8'd200, 8'd17, 12'hAAA);
      // no pulses at all, widest gap, crossed thresholds (spare bits set)
      csr_row(CSR_POS_PER_STEP, 16'd0);
      csr_row(CSR_INDEX_GAP, 16'hFFFF);
      csr_row(CSR_HALL_ON, 16'hF064);
      csr_row(CSR_HALL_OFF, 16'h0BB8);
      // a sample between the levels turns the mark on and off in one tick
      tick_row(16'h4000, 8'd77, 8'd180, 12'd2000);
      tick_row(16'h4000, 8'd77, 8'd180, 12'd2000);
      tick_row(16'hC000, 8'd255, 8'd0, 12'd50);
      // a pulse on every step, zero gap re-zeroes to the origin
      csr_row(CSR_POS_PER_STEP, 16'd1);
      csr_row(CSR_INDEX_GAP, 16'd0);
      tick_row(16'h0010, 8'd128, 8'd64, 12'd2500);
      tick_row(16'h0010, 8'd128, 8'd64, 12'd555);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0) begin
         row = plan_q.pop_front();
         if (row.kind == ROW_CSR) begin
            drain_follow();
            write_csr(row.addr, row.value);
            setting_count++;
         end else begin
            send_tick(row.goal, row.smin, row.smax, row.hall,
                      row.kind == ROW_TICK_TYPED, row.want);
         end
      end

      // -------- random phases, one register setting each ---------------------
      ph_steps = '{16'd59, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd7, 16'd59};
      ph_on    = '{12'd2190, 12'd0, 12'hFFF, 12'd1000, 12'd0, 12'd3000, 12'd2190};
      ph_off   = '{12'd2000, 12'd0, 12'hFFF, 12'd3000, 12'd0, 12'd500, 12'd2000};
      ph_gap   = '{16'd3000, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFE, 16'd3000};
      ph_pace  = '{20, 0, 30, 10, 15, 25, 0};
      ph_stall = '{20, 0, 10, 30, 15, 25, 0};
      // one setting drawn at random, levels kept in the usual order
      ph_steps[4] = 16'($urandom_range(200, 1));
      ph_on[4]    = 12'($urandom_range(4095, 300));
      ph_off[4]   = ph_on[4] - 12'($urandom_range(300, 0));
      ph_gap[4]   = 16'($urandom_range(65535, 0));

      goal_hold = pos_q;
      hall_now  = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_follow();
         pace_pct  = ph_pace[ph];
         stall_pct = ph_stall[ph];
         // hall levels go with random spare bits above the sample width
         write_csr(CSR_POS_PER_STEP, ph_steps[ph]);
         write_csr(CSR_HALL_ON, {4'($urandom), ph_on[ph]});
         write_csr(CSR_HALL_OFF, {4'($urandom), ph_off[ph]});
         write_csr(CSR_INDEX_GAP, ph_gap[ph]);
         setting_count++;
         for (int n = 0; n < PHASE_TICKS; n++) begin
            // mostly hold the goal so the motor gets there and sits
            sel = $urandom_range(99, 0);
            if (sel < 3) begin
               lead = $urandom_range(120, 0) - 60;
               goal_hold = pos_q + 16'(lead);
            end else if (sel < 5) begin
               goal_hold = 16'($urandom);
            end else if (sel < 6) begin
               lead = $urandom_range(4, 0) - 2;
               goal_hold = pos_q + 16'h8000 + 16'(lead);
            end else if (sel < 7) begin
               goal_hold = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            end

            // drift the hall sample so it sweeps through both levels
            sel = $urandom_range(99, 0);
            if (sel < 8)
               hall_now = $urandom_range(4095, 0);
            else if (sel < 12)
               hall_now = $urandom_range(1, 0) ? 4095 : 0;
            else if (sel < 18)
               hall_now = int'(cfg_on) + $urandom_range(4, 0) - 2;
            else if (sel < 24)
               hall_now = int'(cfg_off) + $urandom_range(4, 0) - 2;
            else
               hall_now = hall_now + $urandom_range(400, 0) - 200;
            if (hall_now < 0)
               hall_now = 0;
            if (hall_now > 4095)
               hall_now = 4095;

            sel  = $urandom_range(9, 0);
            smin = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom);
            sel  = $urandom_range(9, 0);
            smax = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom);

            send_tick(goal_hold, smin, smax, 12'(hall_now), 1'b0, '0);
         end
      end

      // -------- wind down ----------------------------------------------------
      drain_follow();
      repeat (40) @(posedge clock);
      if (follow_q.size() != 0) begin
         mismatches += follow_q.size();
         $display("%0d expected responses never arrived", follow_q.size());
      end

      $display("Sent %0d requests under %0d register settings, checked %0d responses.",
               sent_count, setting_count, rsp_count);
      $display("Seen: %0d step pulses, %0d ticks at goal, %0d index re-zeros, %0d mismatches.",
               pulse_count, stop_count, rezero_count, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
